// ===== hw/rtl/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int MODE_BITS   = 2;
    localparam int STATUS_BITS = 2;

    localparam logic [MODE_BITS-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_PEEK   = 2'd2;

    localparam logic [STATUS_BITS-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_BADKEY = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY  = 2'd2;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL   = 2'd3;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic ins;   // insert the broadcast entry in key order
        logic rem;   // shift every entry one cell toward the head
    } spq_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/spq_cell.sv =====
// One slot of the sorted row: holds a key and value, compares against the
// broadcast key and shifts with its neighbors. Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell import spq_pkg::*; #(
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                  aclk,
    input  wire spq_cmd_t              cmd,
    input  wire logic                  occupied,
    input  wire logic [KEY_BITS-1:0]   key_in,
    input  wire logic [VALUE_BITS-1:0] value_in,
    input  wire logic                  left_ahead,
    input  wire logic [KEY_BITS-1:0]   left_key,
    input  wire logic [VALUE_BITS-1:0] left_value,
    input  wire logic [KEY_BITS-1:0]   right_key,
    input  wire logic [VALUE_BITS-1:0] right_value,
    output logic                       ahead,
    output logic [KEY_BITS-1:0]        key,
    output logic [VALUE_BITS-1:0]      value
);

    logic [KEY_BITS-1:0]   key_reg,   key_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;

    // Entry stays ahead of the new key only when strictly smaller.
    assign ahead = occupied && (key_in > key_reg);

    always_comb begin
        key_next   = key_reg;
        value_next = value_reg;
        if (cmd.ins && !ahead) begin
            if (left_ahead) begin
                key_next   = key_in;
                value_next = value_in;
            end else begin
                key_next   = left_key;
                value_next = left_value;
            end
        end else if (cmd.rem) begin
            key_next   = right_key;
            value_next = right_value;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign key   = key_reg;
    assign value = value_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: row of spq_cell slots, entry count
// and result register. Depends on spq_pkg and spq_cell.
`timescale 1ns / 1ps
`default_nettype none

// Min-priority queue of up to DEPTH entries held in key order in a row of
// cells; the head cell always holds the minimum. Each item is an insert,
// remove-minimum or peek; equal keys leave newest first, key zero is
// rejected, inserts into a full queue are dropped. One item is accepted per
// clock cycle while s_tready is high, and its result appears in the output
// register in the next cycle; the rate is set by the single key compare each
// cell does per cycle, with the broadcast key reaching all cells at once. A
// stalled result register holds off s_tready until the result is taken.
module sorted_priority_queue import spq_pkg::*; #(
    parameter int DEPTH      = 16,
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 32,
    localparam int CNT_W     = $clog2(DEPTH + 1),
    localparam int IN_W      = MODE_BITS + KEY_BITS + VALUE_BITS,
    localparam int IN_BYTES_W  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W     = VALUE_BITS + STATUS_BITS + CNT_W + 1,
    localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // mode, key, value (lowest bit first), zero padded
    input  wire logic [IN_BYTES_W-1:0]  s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // value_res, status, count, empty_res (lowest bit first), zero padded
    output logic [OUT_BYTES_W-1:0]      m_tdata
);

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    logic [MODE_BITS-1:0]  in_mode;
    logic [KEY_BITS-1:0]   in_key;
    logic [VALUE_BITS-1:0] in_value;

    assign in_mode  = s_tdata[MODE_BITS-1:0];
    assign in_key   = s_tdata[MODE_BITS +: KEY_BITS];
    assign in_value = s_tdata[MODE_BITS+KEY_BITS +: VALUE_BITS];

    logic accept;
    logic ins_ok, rem_ok, is_read, q_empty, q_full;
    spq_cmd_t cmd;

    logic [CNT_W-1:0] count_reg, count_next;

    logic                  out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0] out_value_reg, out_value_next;
    logic [STATUS_BITS-1:0] out_status_reg, out_status_next;
    logic [CNT_W-1:0]      out_count_reg;
    logic                  out_empty_reg;

    logic                  cell_ahead [DEPTH];
    logic [KEY_BITS-1:0]   cell_key   [DEPTH];
    logic [VALUE_BITS-1:0] cell_value [DEPTH];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign q_empty = (count_reg == '0);
    assign q_full  = (count_reg == DEPTH_CNT);
    assign is_read = (in_mode == MODE_REMOVE) || (in_mode == MODE_PEEK);
    assign ins_ok  = (in_mode == MODE_INSERT) && (in_key != '0) && !q_full;
    assign rem_ok  = (in_mode == MODE_REMOVE) && !q_empty;

    assign cmd.ins = accept && ins_ok;
    assign cmd.rem = accept && rem_ok;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic                  l_ahead;
            logic [KEY_BITS-1:0]   l_key,   r_key;
            logic [VALUE_BITS-1:0] l_value, r_value;
            logic                  occ;

            assign occ = (CNT_W'(gi) < count_reg);

            if (gi == 0) begin : g_head
                assign l_ahead = 1'b1;
                assign l_key   = in_key;
                assign l_value = in_value;
            end else begin : g_body
                assign l_ahead = cell_ahead[gi-1];
                assign l_key   = cell_key[gi-1];
                assign l_value = cell_value[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_tail
                assign r_key   = cell_key[gi];
                assign r_value = cell_value[gi];
            end else begin : g_mid
                assign r_key   = cell_key[gi+1];
                assign r_value = cell_value[gi+1];
            end

            spq_cell #(
                .KEY_BITS   (KEY_BITS),
                .VALUE_BITS (VALUE_BITS)
            ) u_cell (
                .aclk        (aclk),
                .cmd         (cmd),
                .occupied    (occ),
                .key_in      (in_key),
                .value_in    (in_value),
                .left_ahead  (l_ahead),
                .left_key    (l_key),
                .left_value  (l_value),
                .right_key   (r_key),
                .right_value (r_value),
                .ahead       (cell_ahead[gi]),
                .key         (cell_key[gi]),
                .value       (cell_value[gi])
            );
        end
    endgenerate

    always_comb begin
        count_next = count_reg;
        if (cmd.ins) begin
            count_next = count_reg + 1'b1;
        end else if (cmd.rem) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb begin
        out_value_next  = '0;
        out_status_next = STATUS_OK;
        case (in_mode)
            MODE_INSERT: begin
                if (in_key == '0) begin
                    out_status_next = STATUS_BADKEY;
                end else if (q_full) begin
                    out_status_next = STATUS_FULL;
                end
            end
            MODE_REMOVE, MODE_PEEK: begin
                if (q_empty) begin
                    out_status_next = STATUS_EMPTY;
                end else begin
                    out_value_next = cell_value[0];
                end
            end
            default: begin
                out_status_next = STATUS_OK;
            end
        endcase
    end

    // Hold the result until taken; a new item refills the register.
    assign out_valid_next = accept ? 1'b1 : (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
            out_count_reg  <= count_next;
            out_empty_reg  <= (count_next == '0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_BYTES_W'({out_empty_reg, out_count_reg,
                                    out_status_reg, out_value_reg});

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_CNT)
        else $error("entry count above capacity");

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && rem_ok |=> count_reg == $past(count_reg) - 1'b1)
        else $error("remove did not shrink the queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_status_reg == STATUS_EMPTY |->
            out_count_reg == '0 && out_empty_reg && out_value_reg == '0)
        else $error("empty status with entries or data");

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && is_read && !q_empty |=> out_value_reg == $past(cell_value[0]))
        else $error("read result is not the head entry");

    generate
        for (gi = 0; gi + 1 < DEPTH; gi++) begin : g_order_chk
            assert property (@(posedge aclk) disable iff (!aresetn)
                (CNT_W'(gi + 1) < count_reg) |-> cell_key[gi] <= cell_key[gi+1])
                else $error("row out of key order");
        end
    endgenerate
`endif

endmodule

`default_nettype wire
